[rtl/swa_pkg.sv]
// Package for the sliding window average block.
// Holds the sequencer state type and the fixed widths and reset value of the configuration.
// No dependencies.
package swa_pkg;

    // Width and reset value of the window size register.
    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd100;

    // Fraction bits of the Q8 result.
    localparam int FRAC_BITS = 8;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_ADD,
        S_DSTART,
        S_DIV,
        S_OUT
    } state_t;

endpackage

[rtl/swa_div.sv]
// Restoring divider for the sliding window average block: one quotient bit per cycle.
// Unsigned numerator and divisor. The quotient holds after done until the next start.
// No package dependencies.
module swa_div #(
    parameter int NUM_W = 33,
    parameter int DIV_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             take;

    // Trial subtraction of the divisor from the partial remainder.
    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign take    = ~diff[DIV_W];

    // Control: a start loads the operands, then one step per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and the quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= numerator;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], take};
            rem_reg  <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[rtl/sliding_window_average.sv]
// Sliding window average (boxcar filter) top level with its sample ring and sequencer.
// Depends on swa_pkg and swa_div.
//
// Each item carries one signed sample. The block keeps the last window_size samples in a ring
// memory and an exact running sum, and once window_size samples have arrived since the last
// start_of_buffer (or window_size write) it gives one result per item: the window mean in Q8,
// truncated toward zero. A window_size of 0 acts as 1, one above WINDOW_MAX as WINDOW_MAX.
// An item with no result passes S_IDLE, S_SUB and S_ADD; one with a result goes on through
// S_DSTART, S_DIV and S_OUT. S_DIV waits for the shared restoring divider, which yields one
// quotient bit per cycle on NUM_W = SAMPLE_BITS + log2(WINDOW_MAX) + 9 bits. One shared adder
// keeps the running sum: it subtracts the leaving sample and adds the new one in two steps.
module sliding_window_average #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   window_size_we,
    input  logic [8:0]             window_size,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   start_of_buffer,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS+7:0] average_q8
);

    import swa_pkg::*;

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int DIV_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
    localparam int NUM_W = SUM_W + FRAC_BITS;
    localparam int OUT_W = SAMPLE_BITS + FRAC_BITS;
    localparam int LV_W  = DIV_W + 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       window_size_reg;
    logic [DIV_W-1:0]       fill_count_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [PTR_W-1:0]       wp_reg;
    logic                   full_reg;
    logic                   neg_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;

    logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

    logic                   accept;
    logic                   add_en;
    logic                   add_sub;
    logic                   div_start;
    logic                   out_load;
    logic                   out_free;

    logic [31:0]            ws32;
    logic [31:0]            win32;
    logic [DIV_W-1:0]       win;
    logic [DIV_W-1:0]       fill_eff;
    logic                   full;
    logic [LV_W-1:0]        wp_ext;
    logic [LV_W-1:0]        win_ext;
    logic [LV_W-1:0]        leave_ext;
    logic [PTR_W-1:0]       leave_addr;
    logic [SAMPLE_BITS-1:0] operand_raw;
    logic [SUM_W-1:0]       operand;
    logic [SUM_W-1:0]       adder_out;
    logic [SUM_W-1:0]       sum_mag;
    logic [NUM_W-1:0]       numerator;
    logic                   div_done;
    logic [NUM_W-1:0]       quotient;
    logic [NUM_W-1:0]       q_signed;

    // Active window, clamped into one to WINDOW_MAX.
    assign ws32  = 32'(window_size_reg);
    assign win32 = (ws32 == 32'd0) ? 32'd1 :
                   (ws32 > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : ws32;
    assign win   = win32[DIV_W-1:0];

    // A start flag begins the window afresh with this item.
    assign accept   = in_valid & in_ready;
    assign fill_eff = start_of_buffer ? '0 : fill_count_reg;
    assign full     = (fill_eff >= win);

    // Ring slot of the sample that leaves the window.
    assign wp_ext     = LV_W'(wp_reg);
    assign win_ext    = LV_W'(win);
    assign leave_ext  = (wp_ext >= win_ext) ? (wp_ext - win_ext)
                                            : (wp_ext + LV_W'(WINDOW_MAX) - win_ext);
    assign leave_addr = leave_ext[PTR_W-1:0];

    // Shared adder: subtracts the leaving sample or adds the new one.
    assign operand_raw = add_sub ? rd_data_reg : sample_reg;
    assign operand     = {{(SUM_W-SAMPLE_BITS){operand_raw[SAMPLE_BITS-1]}}, operand_raw};
    assign adder_out   = sum_reg + (operand ^ {SUM_W{add_sub}}) + SUM_W'(add_sub);

    // Divider operands: magnitude of the sum scaled to Q8.
    assign sum_mag   = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
    assign numerator = {sum_mag, {FRAC_BITS{1'b0}}};
    assign q_signed  = neg_reg ? (~quotient + NUM_W'(1)) : quotient;

    assign out_free = ~out_valid_reg | out_ready;

    swa_div #(
        .NUM_W (NUM_W),
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (numerator),
        .divisor   (win),
        .done      (div_done),
        .quotient  (quotient)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = (fill_count_reg >= win) ? S_DSTART : S_IDLE;
            end
            S_DSTART:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        add_en    = 1'b0;
        add_sub   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SUB:
            begin
                add_en  = full_reg;
                add_sub = 1'b1;
            end
            S_ADD:
            begin
                add_en = 1'b1;
            end
            S_DSTART:
            begin
                div_start = 1'b1;
            end
            S_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control state, window bookkeeping and the running sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WINDOW_RESET;
            fill_count_reg  <= '0;
            sum_reg         <= '0;
            wp_reg          <= '0;
            full_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (window_size_we)
            begin
                window_size_reg <= window_size;
                fill_count_reg  <= '0;
                sum_reg         <= '0;
            end
            else if (accept)
            begin
                full_reg       <= full;
                fill_count_reg <= full ? fill_eff : (fill_eff + DIV_W'(1));
                wp_reg         <= (wp_reg == PTR_W'(WINDOW_MAX - 1)) ? '0
                                                                     : (wp_reg + PTR_W'(1));
                if (start_of_buffer)
                begin
                    sum_reg <= '0;
                end
            end
            else if (add_en)
            begin
                sum_reg <= adder_out;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
        if (div_start)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (out_load)
        begin
            out_data_reg <= q_signed[OUT_W-1:0];
        end
    end

    // Sample ring: writes the new sample and reads the leaving one on acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring[wp_reg] <= sample;
            rd_data_reg  <= ring[leave_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign average_q8 = out_data_reg;

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // A new result appears only from the output state.
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output state");

    // The fill count never passes the largest window.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= DIV_W'(WINDOW_MAX))
        else $error("fill count beyond the largest window");

    // The write pointer stays inside the ring.
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wp_reg) < 32'(WINDOW_MAX))
        else $error("write pointer outside the ring");

endmodule
